// ===== hw/rtl/stp_pkg.sv =====
// Shared constants and types for the segment to pose transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

    localparam int DEF_COORD_WIDTH    = 32;
    localparam int DEF_ROT_FRAC_BITS  = 30;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH     = 32;
    localparam int CFG_REG_WIDTH      = 31;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COSINE_MARGIN = 2'd1;

    localparam logic [CFG_REG_WIDTH-1:0] MIN_LENGTH_RESET    = 31'd1;
    localparam logic [CFG_REG_WIDTH-1:0] COSINE_MARGIN_RESET = 31'd1;

    typedef struct packed {
        logic empty;
        logic full;
    } stp_queue_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stp_front.sv =====
// Front part: takes segments, forms deltas, midpoint and length (pipelined
// integer square root) and marks degenerate segments. Uses stp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stp_front
    import stp_pkg::*;
#(
    parameter int CW = DEF_COORD_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [CW-1:0]              start_x,
    input  wire logic [CW-1:0]              start_y,
    input  wire logic [CW-1:0]              start_z,
    input  wire logic [CW-1:0]              end_x,
    input  wire logic [CW-1:0]              end_y,
    input  wire logic [CW-1:0]              end_z,
    input  wire logic [CFG_REG_WIDTH-1:0]   min_length,
    input  wire logic                       q_full,
    output logic                            push,
    output logic [2:0][CW-1:0]              e_pos,
    output logic [2:0][CW:0]                e_mag,
    output logic [2:0]                      e_neg,
    output logic [CW:0]                     e_len,
    output logic                            e_degen
);

    localparam int LW  = CW + 1;
    localparam int SW  = 2 * CW + 2;
    localparam int RMW = LW + 3;
    localparam int NI  = CW + 1;
    localparam int CMW = (LW > CFG_REG_WIDTH) ? LW : CFG_REG_WIDTH;

    typedef struct packed {
        logic [2:0][CW-1:0] mid;
        logic [2:0][CW-1:0] start;
        logic [2:0][CW:0]   mag;
        logic [2:0]         neg;
    } fcarry_t;

    logic adv;

    logic [2:0][CW-1:0] s_in;
    logic [2:0][CW-1:0] e_in;
    fcarry_t            a_next;

    logic      a_v_reg;
    fcarry_t   a_c_reg;
    logic      b_v_reg;
    fcarry_t   b_c_reg;
    logic [2:0][SW-1:0] b_sq_reg;
    logic      c_v_reg;
    fcarry_t   c_c_reg;
    logic [SW-1:0] c_n_reg;

    logic           r_v_reg    [NI];
    fcarry_t        r_c_reg    [NI];
    logic [SW-1:0]  r_n_reg    [NI];
    logic [RMW-1:0] r_rem_reg  [NI];
    logic [LW-1:0]  r_root_reg [NI];

    logic               f_v_reg;
    logic [2:0][CW-1:0] f_pos_reg;
    logic [2:0][CW:0]   f_mag_reg;
    logic [2:0]         f_neg_reg;
    logic [LW-1:0]      f_len_reg;
    logic               f_degen_reg;
    logic               degen_next;

    assign adv      = !f_v_reg || !q_full;
    assign in_stall = !adv;

    assign s_in = {start_z, start_y, start_x};
    assign e_in = {end_z, end_y, end_x};

    always_comb
    begin
        logic signed [CW:0] d;
        logic signed [CW:0] t;
        a_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = $signed({e_in[i][CW-1], e_in[i]}) - $signed({s_in[i][CW-1], s_in[i]});
            t = $signed({e_in[i][CW-1], e_in[i]}) + $signed({s_in[i][CW-1], s_in[i]});
            a_next.mid[i]   = t[CW:1];
            a_next.start[i] = s_in[i];
            a_next.neg[i]   = d[CW];
            a_next.mag[i]   = d[CW] ? (LW'(0) - LW'(d)) : LW'(d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_c_reg <= a_next;
            b_c_reg <= a_c_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i] <= a_c_reg.mag[i] * a_c_reg.mag[i];
            end
            c_c_reg <= b_c_reg;
            c_n_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        end
    end

    // square root, two radicand bits per stage
    generate
        for (genvar i = 0; i < NI; i++)
        begin : g_sqrt
            logic           pv;
            fcarry_t        pc;
            logic [SW-1:0]  pn;
            logic [RMW-1:0] prem;
            logic [LW-1:0]  proot;
            logic [RMW-1:0] rem_sh;
            logic [RMW-1:0] trial;
            logic           ge;

            if (i == 0)
            begin : g_first
                assign pv    = c_v_reg;
                assign pc    = c_c_reg;
                assign pn    = c_n_reg;
                assign prem  = '0;
                assign proot = '0;
            end
            else
            begin : g_next
                assign pv    = r_v_reg[i-1];
                assign pc    = r_c_reg[i-1];
                assign pn    = r_n_reg[i-1];
                assign prem  = r_rem_reg[i-1];
                assign proot = r_root_reg[i-1];
            end

            assign rem_sh = {prem[RMW-3:0], pn[SW-1-2*i -: 2]};
            assign trial  = {1'b0, proot, 2'b01};
            assign ge     = rem_sh >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    r_v_reg[i] <= 1'b0;
                end
                else if (adv)
                begin
                    r_v_reg[i] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_c_reg[i]    <= pc;
                    r_n_reg[i]    <= pn;
                    r_rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_root_reg[i] <= {proot[LW-2:0], ge};
                end
            end
        end
    endgenerate

    assign degen_next = CMW'(r_root_reg[NI-1]) <= CMW'(min_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_v_reg <= r_v_reg[NI-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_pos_reg   <= degen_next ? r_c_reg[NI-1].start : r_c_reg[NI-1].mid;
            f_mag_reg   <= r_c_reg[NI-1].mag;
            f_neg_reg   <= r_c_reg[NI-1].neg;
            f_len_reg   <= r_root_reg[NI-1];
            f_degen_reg <= degen_next;
        end
    end

    assign push    = f_v_reg && !q_full;
    assign e_pos   = f_pos_reg;
    assign e_mag   = f_mag_reg;
    assign e_neg   = f_neg_reg;
    assign e_len   = f_len_reg;
    assign e_degen = f_degen_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/stp_queue.sv =====
// Short item queue between the front and back parts.
// Uses stp_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module stp_queue
    import stp_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic [DW-1:0]      pop_data,
    output stp_queue_status_t  status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [DW-1:0]  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CNW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == CNW'(DEPTH);

endmodule

`default_nettype wire

// ===== hw/rtl/stp_back.sv =====
// Back part: direction by pipelined division, parallel tests, Rodrigues
// quotient terms by pipelined division, clamp and output register. Uses stp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stp_back
    import stp_pkg::*;
#(
    parameter int CW = DEF_COORD_WIDTH,
    parameter int RF = DEF_ROT_FRAC_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    output logic                          pop,
    input  wire logic [2:0][CW-1:0]       e_pos,
    input  wire logic [2:0][CW:0]         e_mag,
    input  wire logic [2:0]               e_neg,
    input  wire logic [CW:0]              e_len,
    input  wire logic                     e_degen,
    input  wire logic [CFG_REG_WIDTH-1:0] cosine_margin,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [CW-1:0]                 pos_x,
    output logic [CW-1:0]                 pos_y,
    output logic [CW-1:0]                 pos_z,
    output logic [RF+1:0]                 rot_00,
    output logic [RF+1:0]                 rot_01,
    output logic [RF+1:0]                 rot_02,
    output logic [RF+1:0]                 rot_10,
    output logic [RF+1:0]                 rot_11,
    output logic [RF+1:0]                 rot_12,
    output logic [RF+1:0]                 rot_20,
    output logic [RF+1:0]                 rot_21,
    output logic [RF+1:0]                 rot_22
);

    localparam int LW   = CW + 1;
    localparam int DRW  = LW + 1;
    localparam int ND   = RF + 1;
    localparam int QDW  = RF + 1;
    localparam int RW   = RF + 2;
    localparam int PW   = 2 * RF + 2;
    localparam int QW   = RF + 2;
    localparam int QRW  = RF + 2;
    localparam int NQ   = QW + 1;
    localparam int SUMW = RF + 4;
    localparam int EXW  = ((RW > CFG_REG_WIDTH) ? RW : CFG_REG_WIDTH) + 2;

    localparam logic [RW-1:0]   ONE_RW  = RW'(1) << RF;
    localparam logic [RW-1:0]   NONE_RW = RW'(0) - (RW'(1) << RF);
    localparam logic [SUMW-1:0] ONE_S   = SUMW'(1) << RF;
    localparam logic [EXW-1:0]  ONE_X   = EXW'(1) << RF;

    typedef struct packed {
        logic [2:0][CW-1:0] pos;
        logic [2:0]         neg;
        logic               degen;
    } bcarry_t;

    typedef struct packed {
        logic [2:0][CW-1:0] pos;
        logic               degen;
        logic [RW-1:0]      dx;
        logic [RW-1:0]      dy;
        logic [RW-1:0]      cz;
        logic               anti;
        logic               par;
    } qmeta_t;

    function automatic logic [RW-1:0] clamp_one(input logic [SUMW-1:0] v);
        logic [RW-1:0] r;
        if ($signed(v) > $signed(ONE_S))
        begin
            r = ONE_RW;
        end
        else if ($signed(v) < -$signed(ONE_S))
        begin
            r = NONE_RW;
        end
        else
        begin
            r = v[RW-1:0];
        end
        return r;
    endfunction

    logic adv;

    logic               d_v_reg;
    bcarry_t            d_c_reg;
    logic [2:0][LW-1:0] d_mag_reg;
    logic [LW-1:0]      d_len_reg;

    logic                 dv_v_reg   [ND];
    bcarry_t              dv_c_reg   [ND];
    logic [LW-1:0]        dv_len_reg [ND];
    logic [2:0][DRW-1:0]  dv_rem_reg [ND];
    logic [2:0][QDW-1:0]  dv_q_reg   [ND];

    logic               e_v_reg;
    qmeta_t             e_m_reg;
    logic [QRW-1:0]     e_den_reg;
    logic [2:0][PW-1:0] e_p_reg;
    qmeta_t             e_m_next;
    logic [2:0][PW-1:0] e_p_next;
    logic [RW-1:0]      e_den_next;

    logic                qs_v_reg   [NQ];
    qmeta_t              qs_m_reg   [NQ];
    logic [QRW-1:0]      qs_den_reg [NQ];
    logic [2:0][PW-1:0]  qs_p_reg   [NQ];
    logic [2:0][QRW-1:0] qs_rem_reg [NQ];
    logic [2:0][QW-1:0]  qs_q_reg   [NQ];
    logic [2:0]          qs_ovf_reg [NQ];

    logic                out_valid_reg;
    logic [2:0][CW-1:0]  pos_reg;
    logic [8:0][RW-1:0]  rot_reg;
    logic [8:0][RW-1:0]  rot_next;

    assign adv = !out_valid_reg || !out_stall;
    assign pop = q_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg <= q_valid;
            e_v_reg <= dv_v_reg[ND-1];
            out_valid_reg <= qs_v_reg[NQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_c_reg.pos   <= e_pos;
            d_c_reg.neg   <= e_neg;
            d_c_reg.degen <= e_degen;
            d_mag_reg     <= e_mag;
            d_len_reg     <= e_len;
        end
    end

    // direction: |delta| * 2^RF / length, one quotient bit per stage
    generate
        for (genvar j = 0; j < ND; j++)
        begin : g_dir
            logic                pv;
            bcarry_t             pc;
            logic [LW-1:0]       plen;
            logic [2:0][DRW-1:0] x;
            logic [2:0][QDW-1:0] pq;
            logic [2:0][DRW-1:0] rem_n;
            logic [2:0][QDW-1:0] q_n;

            if (j == 0)
            begin : g_first
                assign pv   = d_v_reg;
                assign pc   = d_c_reg;
                assign plen = d_len_reg;
                assign pq   = '0;
                for (genvar l = 0; l < 3; l++)
                begin : g_l
                    assign x[l] = DRW'(d_mag_reg[l]);
                end
            end
            else
            begin : g_next
                assign pv   = dv_v_reg[j-1];
                assign pc   = dv_c_reg[j-1];
                assign plen = dv_len_reg[j-1];
                assign pq   = dv_q_reg[j-1];
                for (genvar l = 0; l < 3; l++)
                begin : g_l
                    assign x[l] = {dv_rem_reg[j-1][l][DRW-2:0], 1'b0};
                end
            end

            always_comb
            begin
                logic ge;
                q_n = pq;
                for (int l = 0; l < 3; l++)
                begin
                    ge = x[l] >= DRW'(plen);
                    rem_n[l] = ge ? (x[l] - DRW'(plen)) : x[l];
                    q_n[l][RF-j] = ge;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_v_reg[j] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_c_reg[j]   <= pc;
                    dv_len_reg[j] <= plen;
                    dv_rem_reg[j] <= rem_n;
                    dv_q_reg[j]   <= q_n;
                end
            end
        end
    endgenerate

    // signed direction, parallel tests, quotient numerators
    always_comb
    begin
        logic [QDW-1:0] qx;
        logic [QDW-1:0] qy;
        logic [QDW-1:0] qz;
        logic [EXW-1:0] cz_x;
        logic [EXW-1:0] mg_x;
        qx = dv_q_reg[ND-1][0];
        qy = dv_q_reg[ND-1][1];
        qz = dv_q_reg[ND-1][2];
        e_m_next.pos   = dv_c_reg[ND-1].pos;
        e_m_next.degen = dv_c_reg[ND-1].degen;
        e_m_next.dx = dv_c_reg[ND-1].neg[0] ? (RW'(0) - RW'(qx)) : RW'(qx);
        e_m_next.dy = dv_c_reg[ND-1].neg[1] ? (RW'(0) - RW'(qy)) : RW'(qy);
        e_m_next.cz = dv_c_reg[ND-1].neg[2] ? (RW'(0) - RW'(qz)) : RW'(qz);
        cz_x = EXW'($signed(e_m_next.cz));
        mg_x = EXW'(cosine_margin);
        e_m_next.anti = ($signed(cz_x) < $signed(mg_x - ONE_X)) || (e_m_next.cz == NONE_RW);
        e_m_next.par  = $signed(cz_x) >= $signed(ONE_X - mg_x);
        e_den_next = ONE_RW + e_m_next.cz;
        e_p_next[0] = qx * qy;
        e_p_next[1] = qy * qy;
        e_p_next[2] = qx * qx;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_m_reg   <= e_m_next;
            e_den_reg <= e_den_next;
            e_p_reg   <= e_p_next;
        end
    end

    // quotient terms: overflow check, then one quotient bit per stage
    generate
        for (genvar k = 0; k < NQ; k++)
        begin : g_quot
            logic                pv;
            qmeta_t              pm;
            logic [QRW-1:0]      pden;
            logic [2:0][PW-1:0]  pp;
            logic [2:0][QW-1:0]  pq;
            logic [2:0]          povf;
            logic [2:0][QRW-1:0] rem_n;
            logic [2:0][QW-1:0]  q_n;
            logic [2:0]          ovf_n;

            if (k == 0)
            begin : g_first
                assign pv   = e_v_reg;
                assign pm   = e_m_reg;
                assign pden = e_den_reg;
                assign pp   = e_p_reg;
                assign pq   = '0;
                assign povf = '0;
                always_comb
                begin
                    logic [QRW-1:0] hi;
                    q_n = pq;
                    for (int l = 0; l < 3; l++)
                    begin
                        hi = QRW'(pp[l][PW-1:QW]);
                        ovf_n[l] = hi >= pden;
                        rem_n[l] = hi;
                    end
                end
            end
            else
            begin : g_next
                assign pv   = qs_v_reg[k-1];
                assign pm   = qs_m_reg[k-1];
                assign pden = qs_den_reg[k-1];
                assign pp   = qs_p_reg[k-1];
                assign pq   = qs_q_reg[k-1];
                assign povf = qs_ovf_reg[k-1];
                always_comb
                begin
                    logic [QRW-1:0] x;
                    logic           ge;
                    q_n   = pq;
                    ovf_n = povf;
                    for (int l = 0; l < 3; l++)
                    begin
                        x  = {qs_rem_reg[k-1][l][QRW-2:0], pp[l][QW-k]};
                        ge = x >= pden;
                        rem_n[l] = ge ? (x - pden) : x;
                        q_n[l][QW-k] = ge;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    qs_v_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    qs_v_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    qs_m_reg[k]   <= pm;
                    qs_den_reg[k] <= pden;
                    qs_p_reg[k]   <= pp;
                    qs_rem_reg[k] <= rem_n;
                    qs_q_reg[k]   <= q_n;
                    qs_ovf_reg[k] <= ovf_n;
                end
            end
        end
    endgenerate

    always_comb
    begin
        qmeta_t          m;
        logic [QW-1:0]   q_xy;
        logic [QW-1:0]   q_yy;
        logic [QW-1:0]   q_xx;
        logic [SUMW-1:0] cz_s;
        logic [SUMW-1:0] xy_s;
        m    = qs_m_reg[NQ-1];
        q_xy = qs_ovf_reg[NQ-1][0] ? '1 : qs_q_reg[NQ-1][0];
        q_yy = qs_ovf_reg[NQ-1][1] ? '1 : qs_q_reg[NQ-1][1];
        q_xx = qs_ovf_reg[NQ-1][2] ? '1 : qs_q_reg[NQ-1][2];
        cz_s = SUMW'($signed(m.cz));
        xy_s = (m.dx[RW-1] ^ m.dy[RW-1]) ? SUMW'(q_xy) : (SUMW'(0) - SUMW'(q_xy));
        rot_next = '0;
        if (m.degen || (!m.anti && m.par))
        begin
            rot_next[0] = ONE_RW;
            rot_next[4] = ONE_RW;
            rot_next[8] = ONE_RW;
        end
        else if (m.anti)
        begin
            rot_next[0] = ONE_RW;
            rot_next[4] = NONE_RW;
            rot_next[8] = NONE_RW;
        end
        else
        begin
            rot_next[0] = clamp_one(cz_s + SUMW'(q_yy));
            rot_next[1] = clamp_one(xy_s);
            rot_next[2] = m.dx;
            rot_next[3] = clamp_one(xy_s);
            rot_next[4] = clamp_one(cz_s + SUMW'(q_xx));
            rot_next[5] = m.dy;
            rot_next[6] = RW'(0) - m.dx;
            rot_next[7] = RW'(0) - m.dy;
            rot_next[8] = m.cz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg <= qs_m_reg[NQ-1].pos;
            rot_reg <= rot_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x  = pos_reg[0];
    assign pos_y  = pos_reg[1];
    assign pos_z  = pos_reg[2];
    assign rot_00 = rot_reg[0];
    assign rot_01 = rot_reg[1];
    assign rot_02 = rot_reg[2];
    assign rot_10 = rot_reg[3];
    assign rot_11 = rot_reg[4];
    assign rot_12 = rot_reg[5];
    assign rot_20 = rot_reg[6];
    assign rot_21 = rot_reg[7];
    assign rot_22 = rot_reg[8];

endmodule

`default_nettype wire

// ===== hw/rtl/segment_to_pose_transform.sv =====
// Segment to pose transform, top level: config registers, front, queue, back.
// Pipeline depth is set by the one-bit-per-stage square root and the two
// one-bit-per-stage dividers.
// Throughput: one item per cycle when the output is not stalled.
// Reset: asynchronous, clears all valid state; registers return to 1 / 1.
`timescale 1ns / 1ps
`default_nettype none

module segment_to_pose_transform
    import stp_pkg::*;
#(
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    parameter int ROT_FRAC_BITS = DEF_ROT_FRAC_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [COORD_WIDTH-1:0]     start_x,
    input  wire logic [COORD_WIDTH-1:0]     start_y,
    input  wire logic [COORD_WIDTH-1:0]     start_z,
    input  wire logic [COORD_WIDTH-1:0]     end_x,
    input  wire logic [COORD_WIDTH-1:0]     end_y,
    input  wire logic [COORD_WIDTH-1:0]     end_z,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [COORD_WIDTH-1:0]          pos_x,
    output logic [COORD_WIDTH-1:0]          pos_y,
    output logic [COORD_WIDTH-1:0]          pos_z,
    output logic [ROT_FRAC_BITS+1:0]        rot_00,
    output logic [ROT_FRAC_BITS+1:0]        rot_01,
    output logic [ROT_FRAC_BITS+1:0]        rot_02,
    output logic [ROT_FRAC_BITS+1:0]        rot_10,
    output logic [ROT_FRAC_BITS+1:0]        rot_11,
    output logic [ROT_FRAC_BITS+1:0]        rot_12,
    output logic [ROT_FRAC_BITS+1:0]        rot_20,
    output logic [ROT_FRAC_BITS+1:0]        rot_21,
    output logic [ROT_FRAC_BITS+1:0]        rot_22,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int RF = ROT_FRAC_BITS;
    localparam int DW = 3 * CW + 3 * (CW + 1) + 3 + (CW + 1) + 1;

    logic [CFG_REG_WIDTH-1:0] min_length_reg;
    logic [CFG_REG_WIDTH-1:0] cosine_margin_reg;

    logic               push;
    logic               pop;
    stp_queue_status_t  q_stat;
    logic [2:0][CW-1:0] f_pos;
    logic [2:0][CW:0]   f_mag;
    logic [2:0]         f_neg;
    logic [CW:0]        f_len;
    logic               f_degen;
    logic [2:0][CW-1:0] b_pos;
    logic [2:0][CW:0]   b_mag;
    logic [2:0]         b_neg;
    logic [CW:0]        b_len;
    logic               b_degen;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg    <= MIN_LENGTH_RESET;
            cosine_margin_reg <= COSINE_MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_LENGTH:    min_length_reg    <= cfg_data[CFG_REG_WIDTH-1:0];
                REG_COSINE_MARGIN: cosine_margin_reg <= cfg_data[CFG_REG_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    stp_front #(
        .CW (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .min_length (min_length_reg),
        .q_full     (q_stat.full),
        .push       (push),
        .e_pos      (f_pos),
        .e_mag      (f_mag),
        .e_neg      (f_neg),
        .e_len      (f_len),
        .e_degen    (f_degen)
    );

    stp_queue #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_pos, f_mag, f_neg, f_len, f_degen}),
        .pop       (pop),
        .pop_data  ({b_pos, b_mag, b_neg, b_len, b_degen}),
        .status    (q_stat)
    );

    stp_back #(
        .CW (CW),
        .RF (RF)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (!q_stat.empty),
        .pop           (pop),
        .e_pos         (b_pos),
        .e_mag         (b_mag),
        .e_neg         (b_neg),
        .e_len         (b_len),
        .e_degen       (b_degen),
        .cosine_margin (cosine_margin_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .rot_00        (rot_00),
        .rot_01        (rot_01),
        .rot_02        (rot_02),
        .rot_10        (rot_10),
        .rot_11        (rot_11),
        .rot_12        (rot_12),
        .rot_20        (rot_20),
        .rot_21        (rot_21),
        .rot_22        (rot_22)
    );

    localparam logic [RF+1:0] ONE_P = (RF+2)'(1) << RF;

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue empty and full at once");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_rot_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rot_01 == rot_10)
        else $error("off-diagonal terms differ");

    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(rot_00) <= $signed(ONE_P)) && ($signed(rot_00) >= -$signed(ONE_P)))
        else $error("rotation entry out of range");

endmodule

`default_nettype wire
